>>> rtl/lpl_pkg.sv
// package: shared types and constants of the lookahead peak limiter
`timescale 1ns / 1ps
package lpl_pkg;

    localparam int MAX_ATTACK_DEF   = 1024;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_ATTACK_LEN = 3'd1;
    localparam logic [2:0] CFG_ATTACK_COF = 3'd2;
    localparam logic [2:0] CFG_RELEASE_CF = 3'd3;
    localparam logic [2:0] CFG_CHAN_COUNT = 3'd4;
    localparam logic [2:0] CFG_HEADROOM   = 3'd5;
    localparam logic [2:0] CFG_EXTRA_GAIN = 3'd6;

    localparam logic [30:0] THRESHOLD_RST  = 31'h7FFF_FFFF;
    localparam logic [10:0] ATTACK_LEN_RST = 11'd240;
    localparam logic [30:0] ATTACK_COF_RST = 31'd2118123326;
    localparam logic [30:0] RELEASE_CF_RST = 31'd2147170838;
    localparam logic [3:0]  CHAN_COUNT_RST = 4'd2;

    localparam logic signed [31:0] UNITY_GAIN = 32'sh4000_0000;
    localparam logic signed [31:0] CORR_TENTH = 32'sd6554;
    localparam logic signed [31:0] CORR_SCALE = 32'sd18204;
    localparam logic [16:0]        PCM_ROUND  = 17'h08000;

    typedef struct packed {
        logic signed [31:0] sample_in;
        logic [30:0]        frame_gain;
        logic               frame_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [2:0]         out_channel;
        logic               out_last;
        logic [30:0]        gain_now;
    } t_out_beat;

    typedef struct packed {
        logic        start;
        logic [30:0] num;
        logic [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [30:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/lpl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module lpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lpl_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module lpl_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [64:0] o_p
);
    logic signed [64:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

>>> rtl/lpl_div.sv
// iterative q31 divider: normalize one bit a cycle, then 15 restoring steps
`timescale 1ns / 1ps
module lpl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpl_pkg::t_div_req i_req,
    output lpl_pkg::t_div_rsp o_rsp
);
    import lpl_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_NORM = 2'd1;
    localparam logic [1:0] D_LOOP = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    logic [1:0]        r_st;
    logic [30:0]       r_num, r_den;
    logic [4:0]        r_nn, r_nd;
    logic [31:0]       r_a, r_b;
    logic [14:0]       r_q;
    logic [3:0]        r_k;
    logic              r_done;
    logic [30:0]       r_quot;
    logic [31:0]       a2;
    logic signed [6:0] e;
    logic signed [6:0] ne;
    logic [30:0]       rq;
    logic [30:0]       n_quot;

    assign a2 = r_a << 1;
    assign e  = 7'sd1 - $signed({2'b00, r_nn}) + $signed({2'b00, r_nd});
    assign ne = -e;
    assign rq = {r_q, 16'h0000};

    always_comb begin
        if (e > 7'sd0) begin
            if (e > 7'sd30 || rq > (31'h7FFF_FFFF >> e)) begin
                n_quot = 31'h7FFF_FFFF;
            end else begin
                n_quot = rq << e;
            end
        end else if (ne >= 7'sd31) begin
            n_quot = '0;
        end else begin
            n_quot = rq >> ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                D_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.num == '0 || i_req.den == '0) begin
                            r_quot <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_num <= i_req.num;
                            r_den <= i_req.den;
                            r_nn  <= '0;
                            r_nd  <= '0;
                            r_st  <= D_NORM;
                        end
                    end
                end
                D_NORM: begin
                    if (!r_num[30]) begin
                        r_num <= r_num << 1;
                        r_nn  <= r_nn + 5'd1;
                    end
                    if (!r_den[30]) begin
                        r_den <= r_den << 1;
                        r_nd  <= r_nd + 5'd1;
                    end
                    if (r_num[30] && r_den[30]) begin
                        r_a  <= {3'b000, r_num[30:2]};
                        r_b  <= {2'b00, r_den[30:1]};
                        r_q  <= '0;
                        r_k  <= '0;
                        r_st <= D_LOOP;
                    end
                end
                D_LOOP: begin
                    if (a2 >= r_b) begin
                        r_a <= a2 - r_b;
                        r_q <= {r_q[13:0], 1'b1};
                    end else begin
                        r_a <= a2;
                        r_q <= {r_q[13:0], 1'b0};
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd14) begin
                        r_st <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_quot <= n_quot;
                    r_done <= 1'b1;
                    r_st   <= D_IDLE;
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

>>> rtl/lookahead_peak_limiter.sv
// lookahead peak limiter top level: sequencer, config registers and stores
//
// Samples enter one channel per beat; a beat that does not close a frame leaves
// the block ready for the next one. A closing beat starts a sequenced pass over
// one shared multiplier and one iterative divider: extra gain and peak per
// channel (S_GAIN, S_GAINW), the peak window (S_WRD, S_WOLD, S_WPOS) with the
// window ram rescanned one entry a cycle when the maximum leaves the window, the
// divider (normalize plus 15 steps) when the window maximum exceeds the
// threshold, gain smoothing (S_SM0 to S_SM4) and the delayed output beats per
// channel (S_DRD, S_DMUL, S_DOUT), which wait for output ready. Input is not
// taken during that pass. After reset a clearing pass zeroes the delay and
// window rams before the first beat is taken; config writes are taken throughout.
`timescale 1ns / 1ps
module lookahead_peak_limiter #(
    parameter int MAX_ATTACK   = lpl_pkg::MAX_ATTACK_DEF,
    parameter int MAX_CHANNELS = lpl_pkg::MAX_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpl_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpl_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    import lpl_pkg::*;

    localparam int ATT_W    = $clog2(MAX_ATTACK + 1);
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
    localparam int PW_DEPTH = MAX_ATTACK + 1;
    localparam int DL_DEPTH = MAX_ATTACK * MAX_CHANNELS;
    localparam int DL_W     = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
    localparam int CLR_LEN  = (DL_DEPTH > PW_DEPTH) ? DL_DEPTH : PW_DEPTH;
    localparam int CLR_W    = $clog2(CLR_LEN);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_GAIN  = 5'd2;
    localparam logic [4:0] S_GAINW = 5'd3;
    localparam logic [4:0] S_WRD   = 5'd4;
    localparam logic [4:0] S_WOLD  = 5'd5;
    localparam logic [4:0] S_SCAN  = 5'd6;
    localparam logic [4:0] S_SCANE = 5'd7;
    localparam logic [4:0] S_WPOS  = 5'd8;
    localparam logic [4:0] S_DIV   = 5'd9;
    localparam logic [4:0] S_SM0   = 5'd10;
    localparam logic [4:0] S_SM1   = 5'd11;
    localparam logic [4:0] S_SM2   = 5'd12;
    localparam logic [4:0] S_SM3   = 5'd13;
    localparam logic [4:0] S_SM4   = 5'd14;
    localparam logic [4:0] S_DRD   = 5'd15;
    localparam logic [4:0] S_DMUL  = 5'd16;
    localparam logic [4:0] S_DOUT  = 5'd17;

    function automatic logic [30:0] sat_abs(input logic signed [31:0] x);
        logic signed [31:0] nx;
        nx = -x;
        if (!x[31]) begin
            sat_abs = x[30:0];
        end else if (x == 32'sh8000_0000) begin
            sat_abs = 31'h7FFF_FFFF;
        end else begin
            sat_abs = nx[30:0];
        end
    endfunction

    function automatic logic signed [31:0] qm(input logic signed [64:0] p);
        qm = {p[62:32], 1'b0};
    endfunction

    function automatic logic signed [15:0] to_pcm(input logic signed [31:0] t,
                                                  input logic [3:0] hs);
        logic [4:0]         rs;
        logic signed [33:0] v;
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [33:0] w;
        rs = {1'b0, hs} + 5'd1;
        v  = 34'(t) + $signed({17'b0, PCM_ROUND >> rs});
        hi = $signed({3'b000, 31'h7FFF_FFFF >> rs});
        lo = -($signed(34'd1) <<< (5'd31 - rs));
        w  = v <<< rs;
        if (v > hi) begin
            to_pcm = 16'sh7FFF;
        end else if (v < lo) begin
            to_pcm = 16'sh8000;
        end else begin
            to_pcm = w[31:16];
        end
    endfunction

    logic [4:0]                r_state;
    logic [CLR_W-1:0]          r_clr;
    logic [30:0]               r_thr_reg;
    logic [10:0]               r_att_len;
    logic [30:0]               r_att_coef;
    logic [30:0]               r_rel_coef;
    logic [3:0]                r_ch_cnt;
    logic [3:0]                r_hs;
    logic                      r_eg;
    logic signed [31:0]        r_hold [MAX_CHANNELS];
    logic [CNT_W-1:0]          r_chan;
    logic [CNT_W-1:0]          r_count;
    logic [30:0]               r_fg;
    logic [CNT_W-1:0]          r_j;
    logic [30:0]               r_peak;
    logic [ATT_W-1:0]          r_wp;
    logic [ATT_W-1:0]          r_dp;
    logic [30:0]               r_wmax;
    logic signed [31:0]        r_aim;
    logic signed [31:0]        r_s;
    logic signed [31:0]        r_gain;
    logic [ATT_W-1:0]          r_scan;
    logic                      r_pend;
    logic                      r_br;
    logic [DL_W-1:0]           r_idx;
    t_out_beat                 r_out;
    logic                      r_out_vld;

    logic [ATT_W-1:0]          att_c;
    logic [CNT_W-1:0]          cc_c;
    logic [30:0]               thr;
    logic                      acc;
    logic [CH_W-1:0]           hold_wi;
    logic [CNT_W-1:0]          chan_inc;
    logic                      closes;
    logic                      ch_last;
    logic signed [31:0]        v;
    logic signed [31:0]        x_new;
    logic [30:0]               x_abs;
    logic                      st;
    logic [30:0]               pk_c;
    logic [ATT_W-1:0]          wp_c;
    logic [ATT_W:0]            wp_inc;
    logic [ATT_W-1:0]          dp_c;
    logic [ATT_W:0]            dp_inc;
    logic signed [32:0]        d;
    logic signed [31:0]        c;
    logic signed [31:0]        q;
    logic signed [31:0]        t_att;
    logic signed [32:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [64:0]        mul_p;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic                      pw_we;
    logic [ATT_W-1:0]          pw_waddr;
    logic [30:0]               pw_wdata;
    logic [ATT_W-1:0]          pw_raddr;
    logic [30:0]               pw_rd;
    logic                      dl_we;
    logic [DL_W-1:0]           dl_waddr;
    logic [31:0]               dl_wdata;
    logic [31:0]               dl_rd;
    logic                      out_load;

    always_comb begin
        if (r_att_len == '0) begin
            att_c = ATT_W'(1);
        end else if (int'(r_att_len) > MAX_ATTACK) begin
            att_c = ATT_W'(MAX_ATTACK);
        end else begin
            att_c = ATT_W'(r_att_len);
        end
        if (r_ch_cnt == '0) begin
            cc_c = CNT_W'(1);
        end else if (int'(r_ch_cnt) > MAX_CHANNELS) begin
            cc_c = CNT_W'(MAX_CHANNELS);
        end else begin
            cc_c = CNT_W'(r_ch_cnt);
        end
    end

    assign thr        = r_thr_reg >> r_hs;
    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid & o_in_ready;
    assign hold_wi    = (int'(r_chan) >= MAX_CHANNELS) ? '0 : r_chan[CH_W-1:0];
    assign chan_inc   = CNT_W'(hold_wi) + CNT_W'(1);
    assign closes     = i_in_beat.frame_end || (chan_inc >= cc_c);
    assign ch_last    = (CNT_W'(r_j + CNT_W'(1)) == cc_c);

    // extra gain and peak per channel
    assign v      = (r_j < r_count) ? r_hold[r_j[CH_W-1:0]] : '0;
    assign x_new  = (r_state == S_GAINW) ? qm(mul_p) : v;
    assign x_abs  = sat_abs(x_new);
    assign st     = ((r_state == S_GAIN) && !r_eg) || (r_state == S_GAINW);
    assign pk_c   = (r_peak < thr) ? thr : r_peak;
    assign wp_c   = (int'(r_wp) > MAX_ATTACK) ? '0 : r_wp;
    assign wp_inc = {1'b0, r_wp} + (ATT_W + 1)'(1);
    assign dp_c   = (int'(r_dp) >= MAX_ATTACK) ? '0 : r_dp;
    assign dp_inc = {1'b0, r_dp} + (ATT_W + 1)'(1);

    // smoothing terms
    assign d     = 33'(r_gain) - $signed(mul_p[48:16]);
    assign c     = {mul_p[45:16], 2'b00};
    assign q     = qm(mul_p);
    assign t_att = q + r_aim;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state) inside
            S_GAIN: begin
                mul_a = 33'(v);
                mul_b = $signed({1'b0, r_fg});
            end
            S_SM0: begin
                mul_a = 33'(r_s);
                mul_b = CORR_TENTH;
            end
            S_SM1: begin
                mul_a = d;
                mul_b = CORR_SCALE;
            end
            S_SM3: begin
                if (r_aim < r_s) begin
                    mul_a = $signed({2'b00, r_att_coef});
                    mul_b = r_s - r_aim;
                end else begin
                    mul_a = $signed({2'b00, r_rel_coef});
                    mul_b = r_aim - r_s;
                end
            end
            S_DMUL, S_DOUT: begin
                mul_a = 33'($signed(dl_rd));
                mul_b = r_s;
            end
            default: ;
        endcase
    end

    lpl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_req.start = (r_state == S_WPOS) && (r_wmax > thr);
    assign div_req.num   = thr;
    assign div_req.den   = r_wmax;

    lpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign pw_we    = ((r_state == S_CLEAR) && (int'(r_clr) < PW_DEPTH))
                      || (r_state == S_WOLD);
    assign pw_waddr = (r_state == S_CLEAR) ? ATT_W'(r_clr) : r_wp;
    assign pw_wdata = (r_state == S_CLEAR) ? '0 : r_peak;
    assign pw_raddr = (r_state == S_WRD) ? wp_c : r_scan;

    lpl_ram #(
        .WIDTH (31),
        .DEPTH (PW_DEPTH)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (pw_we),
        .i_waddr (pw_waddr),
        .i_wdata (pw_wdata),
        .i_raddr (pw_raddr),
        .o_rdata (pw_rd)
    );

    assign out_load = (r_state == S_DOUT) && (!r_out_vld || i_out_ready);

    // delayed sample is replaced only when its output beat is loaded into the output register
    assign dl_we    = ((r_state == S_CLEAR) && (int'(r_clr) < DL_DEPTH))
                      || out_load;
    assign dl_waddr = (r_state == S_CLEAR) ? DL_W'(r_clr) : r_idx;
    assign dl_wdata = (r_state == S_CLEAR) ? '0 : r_hold[r_j[CH_W-1:0]];

    lpl_ram #(
        .WIDTH (32),
        .DEPTH (DL_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (r_idx),
        .o_rdata (dl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_thr_reg  <= THRESHOLD_RST;
            r_att_len  <= ATTACK_LEN_RST;
            r_att_coef <= ATTACK_COF_RST;
            r_rel_coef <= RELEASE_CF_RST;
            r_ch_cnt   <= CHAN_COUNT_RST;
            r_hs       <= '0;
            r_eg       <= 1'b0;
            r_chan     <= '0;
            r_wp       <= '0;
            r_dp       <= '0;
            r_wmax     <= '0;
            r_aim      <= UNITY_GAIN;
            r_s        <= UNITY_GAIN;
            r_peak     <= '0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD:  r_thr_reg  <= i_cfg_data;
                    CFG_ATTACK_LEN: r_att_len  <= i_cfg_data[10:0];
                    CFG_ATTACK_COF: r_att_coef <= i_cfg_data;
                    CFG_RELEASE_CF: r_rel_coef <= i_cfg_data;
                    CFG_CHAN_COUNT: r_ch_cnt   <= i_cfg_data[3:0];
                    CFG_HEADROOM:   r_hs       <= i_cfg_data[3:0];
                    CFG_EXTRA_GAIN: r_eg       <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (out_load) begin
                r_out.sample_out  <= to_pcm(q, r_hs);
                r_out.out_channel <= 3'(r_j);
                r_out.out_last    <= ch_last;
                r_out.gain_now    <= r_s[30:0];
                r_out_vld         <= 1'b1;
                r_idx             <= r_idx + DL_W'(1);
                r_j               <= r_j + CNT_W'(1);
            end

            if (st) begin
                r_hold[r_j[CH_W-1:0]] <= x_new;
                if (x_abs > r_peak) begin
                    r_peak <= x_abs;
                end
                r_j <= r_j + CNT_W'(1);
            end

            // window rescan merge
            if (r_pend && (pw_rd > r_wmax)) begin
                r_wmax <= pw_rd;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (int'(r_clr) == CLR_LEN - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_hold[hold_wi] <= i_in_beat.sample_in;
                        r_chan          <= chan_inc;
                        if (closes) begin
                            r_count <= chan_inc;
                            r_chan  <= '0;
                            r_fg    <= i_in_beat.frame_gain;
                            r_j     <= '0;
                            r_peak  <= '0;
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_GAIN: begin
                    if (r_eg) begin
                        r_state <= S_GAINW;
                    end else if (ch_last) begin
                        r_state <= S_WRD;
                    end
                end
                S_GAINW: begin
                    r_state <= ch_last ? S_WRD : S_GAIN;
                end
                S_WRD: begin
                    r_peak  <= pk_c;
                    r_wp    <= wp_c;
                    r_state <= S_WOLD;
                end
                S_WOLD: begin
                    if (r_peak >= r_wmax) begin
                        r_wmax  <= r_peak;
                        r_state <= S_WPOS;
                    end else if (pw_rd >= r_wmax) begin
                        r_wmax  <= '0;
                        r_scan  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_WPOS;
                    end
                end
                S_SCAN: begin
                    r_pend <= 1'b1;
                    r_scan <= r_scan + ATT_W'(1);
                    if (r_scan == att_c) begin
                        r_state <= S_SCANE;
                    end
                end
                S_SCANE: begin
                    r_pend  <= 1'b0;
                    r_state <= S_WPOS;
                end
                S_WPOS: begin
                    if (wp_inc >= ({1'b0, att_c} + (ATT_W + 1)'(1))) begin
                        r_wp <= '0;
                    end else begin
                        r_wp <= wp_inc[ATT_W-1:0];
                    end
                    if (r_wmax > thr) begin
                        r_state <= S_DIV;
                    end else begin
                        r_gain  <= UNITY_GAIN;
                        r_state <= S_SM0;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_gain  <= $signed({2'b00, div_rsp.quot[30:1]});
                        r_state <= S_SM0;
                    end
                end
                S_SM0: begin
                    if (r_gain < r_s) begin
                        r_state <= S_SM1;
                    end else begin
                        r_aim   <= r_gain;
                        r_state <= S_SM3;
                    end
                end
                S_SM1: begin
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    if (c < r_aim) begin
                        r_aim <= c;
                    end
                    r_state <= S_SM3;
                end
                S_SM3: begin
                    r_br    <= (r_aim < r_s);
                    r_state <= S_SM4;
                end
                S_SM4: begin
                    if (r_br) begin
                        r_s <= (t_att < r_gain) ? r_gain : t_att;
                    end else begin
                        r_s <= r_aim - q;
                    end
                    r_dp    <= dp_c;
                    r_idx   <= DL_W'(dp_c) * DL_W'(cc_c);
                    r_j     <= '0;
                    r_state <= S_DRD;
                end
                S_DRD: begin
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_load) begin
                        if (ch_last) begin
                            if (dp_inc >= {1'b0, att_c}) begin
                                r_dp <= '0;
                            end else begin
                                r_dp <= dp_inc[ATT_W-1:0];
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;
endmodule
